### rtl/kcs_pkg.sv
// kcs_pkg: shared constants, codes and control structs of the keymap command store
// used by the channel interfaces and by every module of the block but kcs_ram; no dependencies
package kcs_pkg;

  // store geometry
  localparam int unsigned STORE_BYTES = 2048;
  localparam int unsigned MAX_CHUNK   = 28;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);
  localparam int unsigned SIZE_W      = STORE_AW + 1;

  // field widths
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned CHUNK_W  = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 16;

  // configuration registers
  localparam int unsigned ROWS_W     = 6;
  localparam int unsigned COLS_W     = 6;
  localparam int unsigned VER_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd2;

  localparam logic [ROWS_W-1:0] ROWS_RST = 6'd2;
  localparam logic [COLS_W-1:0] COLS_RST = 6'd2;
  localparam logic [VER_W-1:0]  VER_RST  = 16'd9;

  // derived datapath widths
  localparam int unsigned CELLS_W    = ROWS_W + COLS_W;
  localparam int unsigned DIVISOR_W  = CELLS_W + 1;
  localparam int unsigned DCNT_W     = $clog2(SIZE_W + 1);
  localparam int unsigned LAYERS_W   = 8;
  localparam int unsigned LAYERS_MAX = 255;
  localparam int unsigned USED_W     = LAYERS_W + CELLS_W + 1;
  localparam int unsigned PROD_W     = INDEX_W + CELLS_W;
  localparam int unsigned RC_W       = INDEX_W + COLS_W;
  localparam int unsigned KEY_W      = PROD_W + 1;
  localparam int unsigned KEY_ADDR_W = KEY_W + 2;
  localparam int unsigned BUF_ADDR_W = OFFS_W + 1;
  localparam int unsigned LEN_CMP_W  = CHUNK_W + 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_VERSION  = 3'd0,
    OP_GET_KEY  = 3'd1,
    OP_SET_KEY  = 3'd2,
    OP_LAYERS   = 3'd3,
    OP_GET_BUF  = 3'd4,
    OP_SET_BYTE = 3'd5,
    OP_CLR_FLAG = 3'd6,
    OP_UNKNOWN  = 3'd7
  } opcode_e;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNHANDLED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  typedef enum logic [1:0] {
    ADDR_CLEAR  = 2'd0,
    ADDR_KEY_HI = 2'd1,
    ADDR_KEY_LO = 2'd2,
    ADDR_BUF    = 2'd3
  } addr_sel_e;

  typedef enum logic [2:0] {
    RES_ZERO    = 3'd0,
    RES_VERSION = 3'd1,
    RES_KEY     = 3'd2,
    RES_LAYERS  = 3'd3,
    RES_BYTE    = 3'd4
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic                latch_in;
    logic                key_mul;
    logic                key_sum;
    logic                div_start;
    logic                div_step;
    logic                used_mul;
    logic                ram_we;
    logic                ram_re;
    addr_sel_e           addr_sel;
    logic                cap_hi;
    logic                cap_lo;
    logic                cap_byte;
    logic                flag_set;
    logic                flag_clr;
    logic                out_load;
    res_sel_e            res_sel;
    logic [STATUS_W-1:0] res_status;
    logic                res_last;
    logic                idx_clr;
    logic                idx_inc;
    logic                clr_inc;
  } kcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e opcode;
    logic    clear_done;
    logic    div_done;
    logic    key_oor;
    logic    len_zero;
    logic    buf_last;
    logic    out_free;
  } kcs_stat_t;

endpackage

### rtl/kcs_if.sv
// kcs_if: command and response channel interfaces with valid/ready handshake
// depends on kcs_pkg for field widths
interface kcs_cmd_if;
  import kcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [INDEX_W-1:0]  layer_index;
  logic [INDEX_W-1:0]  row_index;
  logic [INDEX_W-1:0]  column_index;
  logic [CODE_W-1:0]   keycode_in;
  logic [OFFS_W-1:0]   byte_offset;
  logic [CHUNK_W-1:0]  chunk_length;
  logic [BYTE_W-1:0]   data_byte;

  modport source (
    output valid, opcode, layer_index, row_index, column_index, keycode_in,
           byte_offset, chunk_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, layer_index, row_index, column_index, keycode_in,
           byte_offset, chunk_length, data_byte,
    output ready
  );
endinterface

interface kcs_rsp_if;
  import kcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value_out;
  logic                last_of_run;
  logic                updated_flag;

  modport source (
    output valid, status, value_out, last_of_run, updated_flag,
    input  ready
  );
  modport sink (
    input  valid, status, value_out, last_of_run, updated_flag,
    output ready
  );
endinterface

### rtl/kcs_ram.sv
// kcs_ram: generic single-port ram, one write or one read per cycle, registered read
// no dependencies
module kcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kcs_ctrl.sv
// kcs_ctrl: command sequencer of the keymap command store
// depends on kcs_pkg; drives kcs_datapath through kcs_cmd_t, reads kcs_stat_t
module kcs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kcs_pkg::kcs_stat_t stat_i,
  output kcs_pkg::kcs_cmd_t  cmd_o
);
  import kcs_pkg::*;

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_DECODE     = 4'd2;
  localparam logic [3:0] S_KEY_MUL    = 4'd3;
  localparam logic [3:0] S_KEY_SUM    = 4'd4;
  localparam logic [3:0] S_KEY_CHK    = 4'd5;
  localparam logic [3:0] S_KEY_RD_LO  = 4'd6;
  localparam logic [3:0] S_KEY_CAP_LO = 4'd7;
  localparam logic [3:0] S_KEY_WR_LO  = 4'd8;
  localparam logic [3:0] S_DIV        = 4'd9;
  localparam logic [3:0] S_BYTE_WR    = 4'd10;
  localparam logic [3:0] S_BUF_RD     = 4'd11;
  localparam logic [3:0] S_BUF_CAP    = 4'd12;
  localparam logic [3:0] S_EMIT       = 4'd13;

  logic [3:0] state_q, state_d;
  logic       more_bytes;

  assign in_ready_o = (state_q == S_IDLE);
  assign more_bytes = (stat_i.opcode == OP_GET_BUF) && !stat_i.len_zero && !stat_i.buf_last;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.addr_sel = ADDR_CLEAR;
        cmd_o.clr_inc  = 1'b1;
        if (stat_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.opcode)
          OP_GET_KEY, OP_SET_KEY: state_d = S_KEY_MUL;
          OP_LAYERS, OP_SET_BYTE: begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
          OP_GET_BUF: begin
            if (stat_i.len_zero) begin
              state_d = S_EMIT;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          OP_CLR_FLAG: begin
            cmd_o.flag_clr = 1'b1;
            state_d        = S_EMIT;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_KEY_MUL: begin
        cmd_o.key_mul = 1'b1;
        state_d       = S_KEY_SUM;
      end
      S_KEY_SUM: begin
        cmd_o.key_sum = 1'b1;
        state_d       = S_KEY_CHK;
      end
      S_KEY_CHK: begin
        cmd_o.addr_sel = ADDR_KEY_HI;
        if (stat_i.key_oor) begin
          state_d = S_EMIT;
        end else if (stat_i.opcode == OP_GET_KEY) begin
          cmd_o.ram_re = 1'b1;
          state_d      = S_KEY_RD_LO;
        end else begin
          cmd_o.ram_we = 1'b1;
          state_d      = S_KEY_WR_LO;
        end
      end
      S_KEY_RD_LO: begin
        cmd_o.addr_sel = ADDR_KEY_LO;
        cmd_o.ram_re   = 1'b1;
        cmd_o.cap_hi   = 1'b1;
        state_d        = S_KEY_CAP_LO;
      end
      S_KEY_CAP_LO: begin
        cmd_o.cap_lo = 1'b1;
        state_d      = S_EMIT;
      end
      S_KEY_WR_LO: begin
        cmd_o.addr_sel = ADDR_KEY_LO;
        cmd_o.ram_we   = 1'b1;
        cmd_o.flag_set = 1'b1;
        state_d        = S_EMIT;
      end
      S_DIV: begin
        if (!stat_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (stat_i.opcode == OP_LAYERS) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.used_mul = 1'b1;
          state_d = (stat_i.opcode == OP_SET_BYTE) ? S_BYTE_WR : S_BUF_RD;
        end
      end
      S_BYTE_WR: begin
        // datapath drops the write when the offset lies past the used size
        cmd_o.addr_sel = ADDR_BUF;
        cmd_o.ram_we   = 1'b1;
        cmd_o.flag_set = 1'b1;
        state_d        = S_EMIT;
      end
      S_BUF_RD: begin
        cmd_o.addr_sel = ADDR_BUF;
        cmd_o.ram_re   = 1'b1;
        state_d        = S_BUF_CAP;
      end
      S_BUF_CAP: begin
        cmd_o.addr_sel = ADDR_BUF;
        cmd_o.cap_byte = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.res_last = !more_bytes;
        case (stat_i.opcode)
          OP_VERSION: cmd_o.res_sel = RES_VERSION;
          OP_GET_KEY: begin
            cmd_o.res_sel    = stat_i.key_oor ? RES_ZERO : RES_KEY;
            cmd_o.res_status = stat_i.key_oor ? ST_RANGE : ST_OK;
          end
          OP_SET_KEY: cmd_o.res_status = stat_i.key_oor ? ST_RANGE : ST_OK;
          OP_LAYERS:  cmd_o.res_sel = RES_LAYERS;
          OP_GET_BUF: cmd_o.res_sel = stat_i.len_zero ? RES_ZERO : RES_BYTE;
          OP_UNKNOWN: cmd_o.res_status = ST_UNHANDLED;
          default:    cmd_o.res_sel = RES_ZERO;
        endcase
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (more_bytes) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_BUF_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/kcs_datapath.sv
// kcs_datapath: configuration registers, key address math, layer-count divider,
// keymap store and response register; depends on kcs_pkg, kcs_if and kcs_ram
module kcs_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  kcs_cmd_if.sink                         cmd_i,
  kcs_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kcs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  kcs_pkg::kcs_cmd_t               ctl_i,
  output kcs_pkg::kcs_stat_t              stat_o
);
  import kcs_pkg::*;

  // configuration
  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic [VER_W-1:0]  ver_q;
  logic [CELLS_W-1:0] cells_q;

  // latched command
  opcode_e             op_q;
  logic [INDEX_W-1:0]  layer_q, row_q, col_q;
  logic [CODE_W-1:0]   code_q;
  logic [OFFS_W-1:0]   offs_q;
  logic [CHUNK_W-1:0]  len_q;
  logic [BYTE_W-1:0]   dbyte_q;

  // key address
  logic [PROD_W-1:0]     prod_q;
  logic [RC_W-1:0]       rc_q;
  logic [KEY_W-1:0]      key_q;
  logic [KEY_ADDR_W-1:0] key_addr;
  logic                  key_oor;

  // divider
  logic [DIVISOR_W-1:0] rem_q, divisor_q, rem_d;
  logic [SIZE_W-1:0]    dvd_q, quo_q;
  logic [DCNT_W-1:0]    dcnt_q;
  logic [DIVISOR_W:0]   div_shift, div_diff;
  logic                 div_ge;
  logic [LAYERS_W-1:0]  layers;
  logic [USED_W-1:0]    used_q;

  // buffer walk and store
  logic [CHUNK_W-1:0]    idx_q;
  logic [BUF_ADDR_W-1:0] buf_addr;
  logic                  buf_in_range;
  logic [STORE_AW-1:0]   clr_cnt_q;
  logic [STORE_AW-1:0]   ram_addr;
  logic [BYTE_W-1:0]     ram_wdata, ram_rdata;
  logic                  ram_we;
  logic [CODE_W-1:0]     key_val_q;
  logic [BYTE_W-1:0]     byte_q;
  logic                  flag_q;

  // response register
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [VALUE_W-1:0]  rsp_value_q;
  logic                rsp_last_q;
  logic                rsp_flag_q;
  logic [VALUE_W-1:0]  res_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
      ver_q  <= VER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS:    rows_q <= cfg_wdata_i[ROWS_W-1:0];
        CFG_COLS:    cols_q <= cfg_wdata_i[COLS_W-1:0];
        CFG_VERSION: ver_q  <= cfg_wdata_i[VER_W-1:0];
        default: ;
      endcase
    end
  end

  // key address: 2 * (layer*cells + row*cols + col), high byte first
  assign key_addr = {1'b0, key_q, 1'b0};
  assign key_oor  = (key_addr + KEY_ADDR_W'(1)) >= KEY_ADDR_W'(STORE_BYTES);

  // restoring divide of the store size by 2*cells, one quotient bit a cycle
  assign div_shift = {rem_q, dvd_q[SIZE_W-1]};
  assign div_ge    = div_shift >= {1'b0, divisor_q};
  assign div_diff  = div_shift - {1'b0, divisor_q};
  assign rem_d     = div_ge ? div_diff[DIVISOR_W-1:0] : div_shift[DIVISOR_W-1:0];

  always_comb begin
    if (cells_q == '0) begin
      layers = '0;
    end else if (32'(quo_q) > LAYERS_MAX) begin
      layers = LAYERS_W'(LAYERS_MAX);
    end else begin
      layers = LAYERS_W'(quo_q);
    end
  end

  assign buf_addr     = BUF_ADDR_W'(offs_q) + BUF_ADDR_W'(idx_q);
  assign buf_in_range = (32'(buf_addr) < 32'(used_q)) && (32'(buf_addr) < STORE_BYTES);

  always_comb begin
    case (ctl_i.addr_sel)
      ADDR_KEY_HI: begin
        ram_addr  = key_addr[STORE_AW-1:0];
        ram_wdata = code_q[CODE_W-1:BYTE_W];
      end
      ADDR_KEY_LO: begin
        ram_addr  = {key_addr[STORE_AW-1:1], 1'b1};
        ram_wdata = code_q[BYTE_W-1:0];
      end
      ADDR_BUF: begin
        ram_addr  = buf_addr[STORE_AW-1:0];
        ram_wdata = dbyte_q;
      end
      default: begin
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
      end
    endcase
  end

  assign ram_we = ctl_i.ram_we && ((ctl_i.addr_sel != ADDR_BUF) || buf_in_range);

  kcs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ctl_i.ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (ctl_i.res_sel)
      RES_VERSION: res_value = ver_q;
      RES_KEY:     res_value = key_val_q;
      RES_LAYERS:  res_value = VALUE_W'(layers);
      RES_BYTE:    res_value = VALUE_W'(byte_q);
      default:     res_value = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cells_q <= CELLS_W'(rows_q) * CELLS_W'(cols_q);
    if (ctl_i.latch_in) begin
      op_q    <= opcode_e'(cmd_i.opcode);
      layer_q <= cmd_i.layer_index;
      row_q   <= cmd_i.row_index;
      col_q   <= cmd_i.column_index;
      code_q  <= cmd_i.keycode_in;
      offs_q  <= cmd_i.byte_offset;
      dbyte_q <= cmd_i.data_byte;
      if (32'(cmd_i.chunk_length) > MAX_CHUNK) begin
        len_q <= CHUNK_W'(MAX_CHUNK);
      end else begin
        len_q <= cmd_i.chunk_length;
      end
    end
    if (ctl_i.key_mul) begin
      prod_q <= PROD_W'(layer_q) * PROD_W'(cells_q);
      rc_q   <= RC_W'(row_q) * RC_W'(cols_q);
    end
    if (ctl_i.key_sum) begin
      key_q <= KEY_W'(prod_q) + KEY_W'(rc_q) + KEY_W'(col_q);
    end
    if (ctl_i.div_start) begin
      rem_q     <= '0;
      dvd_q     <= SIZE_W'(STORE_BYTES);
      quo_q     <= '0;
      divisor_q <= {cells_q, 1'b0};
    end else if (ctl_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[SIZE_W-2:0], 1'b0};
      quo_q <= {quo_q[SIZE_W-2:0], div_ge};
    end
    if (ctl_i.used_mul) begin
      used_q <= (USED_W'(layers) * USED_W'(cells_q)) << 1;
    end
    if (ctl_i.cap_hi) begin
      key_val_q[CODE_W-1:BYTE_W] <= ram_rdata;
    end
    if (ctl_i.cap_lo) begin
      key_val_q[BYTE_W-1:0] <= ram_rdata;
    end
    if (ctl_i.cap_byte) begin
      byte_q <= buf_in_range ? ram_rdata : '0;
    end
    if (ctl_i.out_load) begin
      rsp_status_q <= ctl_i.res_status;
      rsp_value_q  <= res_value;
      rsp_last_q   <= ctl_i.res_last;
      rsp_flag_q   <= flag_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q      <= 1'b0;
      clr_cnt_q   <= '0;
      idx_q       <= '0;
      dcnt_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (ctl_i.flag_set) begin
        flag_q <= 1'b1;
      end else if (ctl_i.flag_clr) begin
        flag_q <= 1'b0;
      end
      if (ctl_i.clr_inc) begin
        clr_cnt_q <= clr_cnt_q + STORE_AW'(1);
      end
      if (ctl_i.idx_clr) begin
        idx_q <= '0;
      end else if (ctl_i.idx_inc) begin
        idx_q <= idx_q + CHUNK_W'(1);
      end
      if (ctl_i.div_start) begin
        dcnt_q <= '0;
      end else if (ctl_i.div_step) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      if (ctl_i.out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.value_out    = rsp_value_q;
  assign rsp_o.last_of_run  = rsp_last_q;
  assign rsp_o.updated_flag = rsp_flag_q;

  assign stat_o.opcode     = op_q;
  assign stat_o.clear_done = (clr_cnt_q == STORE_AW'(STORE_BYTES - 1));
  assign stat_o.div_done   = (dcnt_q == DCNT_W'(SIZE_W));
  assign stat_o.key_oor    = key_oor;
  assign stat_o.len_zero   = (len_q == '0);
  assign stat_o.buf_last   = (LEN_CMP_W'(idx_q) + LEN_CMP_W'(1)) == LEN_CMP_W'(len_q);
  assign stat_o.out_free   = !rsp_valid_q || rsp_o.ready;

endmodule

### rtl/keymap_command_store_unit.sv
// keymap_command_store_unit: top level of the keymap command store
// depends on kcs_pkg, kcs_if, kcs_ctrl and kcs_datapath
//
//   channel   dir  handshake      contents
//   cmd_i     in   valid/ready    opcode, key address, keycode, offset, length, byte
//   rsp_o     out  valid/ready    status, value_out, last_of_run, updated_flag
//   cfg_*     in   cfg_we_i only  rows (0), columns (1), protocol version (2)
//
// one command at a time; layer count, set byte and get buffer with a nonzero length
// run the divider first (it yields one quotient bit a cycle over the 12-bit store
// size), and get buffer then reads its bytes one by one
// through the single-port store.
// after reset a clearing pass writes zero to all 2048 store bytes, one a cycle,
// with cmd_i not ready; configuration writes are taken throughout.
// a result sits in the output register until taken; the next command is accepted
// meanwhile, and further buffer bytes wait for the register to free.
module keymap_command_store_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  kcs_cmd_if.sink                         cmd_i,
  kcs_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kcs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import kcs_pkg::*;

  kcs_cmd_t  ctl_cmd;
  kcs_stat_t dp_stat;
  logic      in_ready;

  assign cmd_i.ready = in_ready;

  kcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  kcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl_cmd),
    .stat_o      (dp_stat)
  );

  // one item in flight: no second accept right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !cmd_i.ready)
    else $error("command accepted on back-to-back cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.status == ST_OK || rsp_o.status == ST_UNHANDLED ||
                     rsp_o.status == ST_RANGE))
    else $error("undefined status code");

  // error results always close their command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_OK |-> rsp_o.last_of_run)
    else $error("error result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.ram_we && ctl_cmd.addr_sel == ADDR_CLEAR |-> !cmd_i.ready)
    else $error("command taken during clearing pass");

endmodule

### verif/tb_keymap_command_store_unit.sv
// tb_keymap_command_store_unit: self-checking bench for the keymap command store
// drives commands through kcs_cmd_if, predicts every reply from a shadow keymap and checks
// replies on kcs_rsp_if; depends on kcs_pkg, kcs_if and keymap_command_store_unit
`timescale 1ns / 1ps

module tb_keymap_command_store_unit;
  import kcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE       = 24;
  localparam int unsigned PRINT_LIMIT  = 40;

  typedef struct packed {
    opcode_e              op;
    logic [INDEX_W-1:0]   layer;
    logic [INDEX_W-1:0]   row;
    logic [INDEX_W-1:0]   col;
    logic [CODE_W-1:0]    keycode;
    logic [OFFS_W-1:0]    offset;
    logic [CHUNK_W-1:0]   chunk;
    logic [BYTE_W-1:0]    dbyte;
  } key_command_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [VALUE_W-1:0]   value;
    logic                 last;
    logic                 flag;
  } key_reply_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  kcs_cmd_if cmd_ch ();
  kcs_rsp_if rsp_ch ();

  keymap_command_store_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow copy of the store and its registers
  logic [BYTE_W-1:0] shadow_keymap [STORE_BYTES];
  logic              shadow_changed;
  int unsigned       shadow_rows;
  int unsigned       shadow_cols;
  logic [VER_W-1:0]  shadow_version;

  key_reply_t  owed_responses [$];
  int unsigned error_count;
  int unsigned replies_checked;
  int unsigned commands_sent;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d replies still owed", cycle_count,
             owed_responses.size());
    $display("tb_keymap_command_store_unit: errors");
    $finish;
  end

  // receiver side: random stalls plus a counted hold-off on request
  initial begin : drive_reply_ready
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at reply %0d: %s got 0x%0h expected 0x%0h", replies_checked,
               what, got, want);
  endtask

  always @(posedge clk_i) begin : check_replies
    key_reply_t want;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (owed_responses.size() == 0) begin
        report_mismatch("reply with nothing owed, value", 32'(rsp_ch.value_out), 0);
      end else begin
        want = owed_responses.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.value_out !== want.value)
          report_mismatch("value_out", 32'(rsp_ch.value_out), 32'(want.value));
        if (rsp_ch.last_of_run !== want.last)
          report_mismatch("last_of_run", 32'(rsp_ch.last_of_run), 32'(want.last));
        if (rsp_ch.updated_flag !== want.flag)
          report_mismatch("updated_flag", 32'(rsp_ch.updated_flag), 32'(want.flag));
        replies_checked++;
      end
    end
  end

  function automatic int unsigned layer_count();
    int unsigned cells;
    int unsigned n;
    cells = shadow_rows * shadow_cols;
    if (cells == 0) return 0;
    n = STORE_BYTES / (2 * cells);
    return (n > LAYERS_MAX) ? LAYERS_MAX : n;
  endfunction

  function automatic int unsigned used_bytes();
    return layer_count() * shadow_rows * shadow_cols * 2;
  endfunction

  function automatic void owe_reply(input logic [STATUS_W-1:0] status,
                                    input logic [VALUE_W-1:0] value, input logic last);
    key_reply_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    r.flag   = shadow_changed;
    owed_responses.push_back(r);
  endfunction

  // applies one command to the shadow store and queues the replies it owes
  function automatic void keymap_command_outcome(input key_command_t c);
    int unsigned key_addr;
    int unsigned len;
    int unsigned used;
    int unsigned a;
    int unsigned i;
    logic [VALUE_W-1:0] v;
    case (c.op)
      OP_VERSION: owe_reply(ST_OK, shadow_version, 1'b1);
      OP_GET_KEY, OP_SET_KEY: begin
        key_addr = 2 * (c.layer * shadow_rows * shadow_cols + c.row * shadow_cols + c.col);
        if (key_addr + 1 >= STORE_BYTES) begin
          owe_reply(ST_RANGE, '0, 1'b1);
        end else if (c.op == OP_GET_KEY) begin
          owe_reply(ST_OK, {shadow_keymap[key_addr], shadow_keymap[key_addr + 1]}, 1'b1);
        end else begin
          shadow_keymap[key_addr]     = c.keycode[15:8];
          shadow_keymap[key_addr + 1] = c.keycode[7:0];
          shadow_changed = 1'b1;
          owe_reply(ST_OK, '0, 1'b1);
        end
      end
      OP_LAYERS: owe_reply(ST_OK, VALUE_W'(layer_count()), 1'b1);
      OP_GET_BUF: begin
        len = (c.chunk > MAX_CHUNK) ? MAX_CHUNK : c.chunk;
        if (len == 0) begin
          owe_reply(ST_OK, '0, 1'b1);
        end else begin
          used = used_bytes();
          for (i = 0; i < len; i++) begin
            a = c.offset + i;
            v = '0;
            if (a < used && a < STORE_BYTES) v = VALUE_W'(shadow_keymap[a]);
            owe_reply(ST_OK, v, (i + 1 == len));
          end
        end
      end
      OP_SET_BYTE: begin
        used = used_bytes();
        if (c.offset < used && c.offset < STORE_BYTES) shadow_keymap[c.offset] = c.dbyte;
        shadow_changed = 1'b1;
        owe_reply(ST_OK, '0, 1'b1);
      end
      OP_CLR_FLAG: begin
        shadow_changed = 1'b0;
        owe_reply(ST_OK, '0, 1'b1);
      end
      default: owe_reply(ST_UNHANDLED, '0, 1'b1);
    endcase
  endfunction

  function automatic key_command_t make_command(input opcode_e op, input int unsigned layer,
      input int unsigned row, input int unsigned col, input int unsigned keycode,
      input int unsigned offset, input int unsigned chunk, input int unsigned dbyte);
    key_command_t c;
    c.op      = op;
    c.layer   = INDEX_W'(layer);
    c.row     = INDEX_W'(row);
    c.col     = INDEX_W'(col);
    c.keycode = CODE_W'(keycode);
    c.offset  = OFFS_W'(offset);
    c.chunk   = CHUNK_W'(chunk);
    c.dbyte   = BYTE_W'(dbyte);
    return c;
  endfunction

  // mostly keys and offsets inside the current geometry, some raw noise
  function automatic key_command_t random_command();
    key_command_t c;
    int unsigned pick;
    int unsigned lc;
    c = make_command(OP_VERSION, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 18)      c.op = OP_GET_KEY;
    else if (pick < 38) c.op = OP_SET_KEY;
    else if (pick < 58) c.op = OP_GET_BUF;
    else if (pick < 72) c.op = OP_SET_BYTE;
    else if (pick < 78) c.op = OP_VERSION;
    else if (pick < 84) c.op = OP_LAYERS;
    else if (pick < 92) c.op = OP_CLR_FLAG;
    else                c.op = OP_UNKNOWN;
    lc = layer_count();
    if ($urandom_range(99) < 85) begin
      c.layer = INDEX_W'($urandom_range(0, (lc == 0) ? 0 : lc - 1));
      c.row   = INDEX_W'($urandom_range(0, (shadow_rows == 0) ? 0 : shadow_rows - 1));
      c.col   = INDEX_W'($urandom_range(0, (shadow_cols == 0) ? 0 : shadow_cols - 1));
    end
    if ($urandom_range(99) < 85) c.offset = OFFS_W'($urandom_range(0, used_bytes() + 4));
    if ($urandom_range(99) < 80) c.chunk = CHUNK_W'($urandom_range(0, MAX_CHUNK));
    return c;
  endfunction

  // entered and left at a falling edge
  task automatic send_command(input key_command_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid        = 1'b1;
    cmd_ch.opcode       = c.op;
    cmd_ch.layer_index  = c.layer;
    cmd_ch.row_index    = c.row;
    cmd_ch.column_index = c.col;
    cmd_ch.keycode_in   = c.keycode;
    cmd_ch.byte_offset  = c.offset;
    cmd_ch.chunk_length = c.chunk;
    cmd_ch.data_byte    = c.dbyte;
    @(posedge clk_i);
    while (cmd_ch.ready !== 1'b1) @(posedge clk_i);
    keymap_command_outcome(c);
    commands_sent++;
    @(negedge clk_i);
  endtask

  task automatic await_replies();
    cmd_ch.valid = 1'b0;
    while (owed_responses.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_ROWS:    shadow_rows    = data[ROWS_W-1:0];
      CFG_COLS:    shadow_cols    = data[COLS_W-1:0];
      CFG_VERSION: shadow_version = data[VER_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits of the geometry words carry junk that must be dropped
  task automatic program_geometry(input int unsigned rows, input int unsigned cols,
                                  input int unsigned version);
    logic [CFG_DATA_W-1:0] word;
    await_replies();
    word = CFG_DATA_W'($urandom);
    word[ROWS_W-1:0] = ROWS_W'(rows);
    write_register(CFG_ROWS, word);
    word = CFG_DATA_W'($urandom);
    word[COLS_W-1:0] = COLS_W'(cols);
    write_register(CFG_COLS, word);
    write_register(CFG_VERSION, CFG_DATA_W'(version));
  endtask

  // reset geometry 2x2: layer count saturates and the store runs on past the used size
  task automatic test_directed_commands();
    send_command(make_command(OP_VERSION, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_LAYERS, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_GET_KEY, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_SET_KEY, 0, 0, 0, 16'hFFFF, 0, 0, 0));
    send_command(make_command(OP_GET_KEY, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_CLR_FLAG, 0, 0, 0, 0, 0, 0, 0));
    // last key that fits in the store
    send_command(make_command(OP_SET_KEY, 255, 1, 1, 16'hA55A, 0, 0, 0));
    send_command(make_command(OP_GET_KEY, 255, 1, 1, 0, 0, 0, 0));
    send_command(make_command(OP_CLR_FLAG, 0, 0, 0, 0, 0, 0, 0));
    // keys past the end of the store
    send_command(make_command(OP_SET_KEY, 255, 2, 0, 16'h1234, 0, 0, 0));
    send_command(make_command(OP_GET_KEY, 255, 255, 255, 0, 0, 0, 0));
    send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, 0, 1, 0));
    send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, 0, 31, 0));
    send_command(make_command(OP_SET_BYTE, 0, 0, 0, 0, 2039, 0, 8'h80));
    send_command(make_command(OP_CLR_FLAG, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_command(OP_SET_BYTE, 0, 0, 0, 0, 2040, 0, 8'h7F));
    send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, 2036, 12, 0));
    send_command(make_command(OP_SET_BYTE, 0, 0, 0, 0, 16'hFFFF, 0, 8'hFF));
    send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, 16'hFFFF, MAX_CHUNK, 0));
    send_command(make_command(OP_UNKNOWN, 255, 255, 255, 16'hFFFF, 16'hFFFF, 31, 8'hFF));
  endtask

  // single cell, full store, empty geometry either way, oversized and thin geometries
  task automatic test_geometry_extremes();
    int unsigned rows_set [6] = '{1, 32, 0, 5, 63, 32};
    int unsigned cols_set [6] = '{1, 32, 5, 0, 63, 1};
    int unsigned ver_set  [6] = '{0, 16'hFFFF, 16'h1234, 16'h8001, 16'h00FF, 16'h7FFE};
    int unsigned lc;
    int unsigned used;
    int unsigned kl;
    int unsigned kr;
    int unsigned kc;
    for (int k = 0; k < 6; k++) begin
      program_geometry(rows_set[k], cols_set[k], ver_set[k]);
      lc   = layer_count();
      used = used_bytes();
      kl   = (lc == 0) ? 0 : lc - 1;
      kr   = (shadow_rows == 0) ? 0 : shadow_rows - 1;
      kc   = (shadow_cols == 0) ? 0 : shadow_cols - 1;
      send_command(make_command(OP_VERSION, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_command(OP_LAYERS, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_command(OP_SET_KEY, kl, kr, kc, $urandom, 0, 0, 0));
      send_command(make_command(OP_GET_KEY, kl, kr, kc, 0, 0, 0, 0));
      // the last key is the last two used bytes; the third byte reads past the end
      send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, (used - 2) & 16'hFFFF, 3, 0));
      send_command(make_command(OP_SET_BYTE, 0, 0, 0, 0, (used - 1) & 16'hFFFF, 0,
                                $urandom));
      send_command(make_command(OP_SET_BYTE, 0, 0, 0, 0, used, 0, $urandom));
    end
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    program_geometry($urandom_range(1, 12), $urandom_range(1, 12), $urandom);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_command(random_command());
  endtask

  // receiver holds off long enough for the store to stop taking commands
  task automatic test_output_backpressure();
    program_geometry(4, 6, $urandom);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 400;
    send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, 0, MAX_CHUNK, 0));
    send_command(make_command(OP_SET_KEY, 1, 2, 3, $urandom, 0, 0, 0));
    send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, 60, MAX_CHUNK, 0));
    repeat (5) send_command(random_command());
    send_command(make_command(OP_GET_BUF, 0, 0, 0, 0, 0, MAX_CHUNK, 0));
    send_command(make_command(OP_LAYERS, 0, 0, 0, 0, 0, 0, 0));
    await_replies();
  endtask

  initial begin : stimulus
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_ROWS;
    cfg_wdata_i         = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.opcode       = OP_VERSION;
    cmd_ch.layer_index  = '0;
    cmd_ch.row_index    = '0;
    cmd_ch.column_index = '0;
    cmd_ch.keycode_in   = '0;
    cmd_ch.byte_offset  = '0;
    cmd_ch.chunk_length = '0;
    cmd_ch.data_byte    = '0;
    foreach (shadow_keymap[i]) shadow_keymap[i] = '0;
    shadow_changed  = 1'b0;
    shadow_rows     = ROWS_RST;
    shadow_cols     = COLS_RST;
    shadow_version  = VER_RST;
    error_count     = 0;
    replies_checked = 0;
    commands_sent   = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_commands();
    test_geometry_extremes();
    test_random_traffic(36, 0, 0);
    test_random_traffic(36, 75, 0);
    test_random_traffic(36, 0, 75);
    test_random_traffic(36, 20, 20);
    test_output_backpressure();

    await_replies();
    repeat (120) @(negedge clk_i);
    $display("%0d commands sent, %0d replies checked, %0d mismatches", commands_sent,
             replies_checked, error_count);
    $display("covered reset and extreme geometries, keys off the store, chunk limits, stalls");
    if (error_count == 0) begin
      $display("tb_keymap_command_store_unit: clean");
    end else begin
      $display("tb_keymap_command_store_unit: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/kcs_pkg.sv
rtl/kcs_if.sv
rtl/kcs_ram.sv
rtl/kcs_ctrl.sv
rtl/kcs_datapath.sv
rtl/keymap_command_store_unit.sv
verif/tb_keymap_command_store_unit.sv
